// File: hw/rtl/sparse_table_range_min_index_defines.svh
// Assertion macros for the sparse table range-minimum block.
// Used by the checker module; no other dependencies.
`ifndef SPARSE_TABLE_RANGE_MIN_INDEX_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_INDEX_DEFINES_SVH
// Implication checked every clock edge, off during reset.
`define ST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication.
`define ST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

// File: hw/rtl/stm_pkg.sv
// Package for the sparse table range-minimum block: beat types and codes.
// No dependencies.
`timescale 1ns / 1ps
package stm_pkg;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int   REG_SELECT_MAX = 0;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] value;
        logic               last;
        logic [10:0]        left;
        logic [10:0]        right;
    } stm_in_t;

    typedef struct packed {
        logic [10:0] best_index;
        logic        error;
    } stm_out_t;
endpackage

// File: hw/rtl/stm_cmp.sv
// Shared strict compare unit: picks left candidate only if strictly better.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps
module stm_cmp #(
    parameter int KW = 32
) (
    input  logic [KW-1:0] key_a,
    input  logic [KW-1:0] key_b,
    input  logic          use_max,
    output logic          take_a
);
    assign take_a = use_max ? (key_a > key_b) : (key_a < key_b);
endmodule

// File: hw/rtl/sparse_table_range_min_index.sv
// Top level of the sparse table range-minimum block: sequencer and memories.
// Depends on stm_pkg and stm_cmp.
//
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_ready  stm_in_t  (load or query)
// out      out  out_valid/out_ready stm_out_t (query answer)
// cfg      in   APB psel/penable   select_max at address 0
//
// A load writes its element in S_LOAD; the last load then runs the build pass,
// S_BLD0 through S_BLDW for each table entry (n log n entries) plus one S_BLD0
// step per level, set by one shared compare and single-port element and table
// memories. A query steps S_QLOG per bit of log2 of the range length, then QA-QOUT.
// Reset clears control state only; memories are undefined until written.
// in_ready is low while busy or while an answer waits in the output register.
`timescale 1ns / 1ps
module sparse_table_range_min_index
    import stm_pkg::*;
#(
    parameter int MAX_ELEMS   = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  stm_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output stm_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW  = $clog2(MAX_ELEMS);     // element address bits
    localparam int CW  = AW + 1;                 // count bits
    localparam int LV  = AW + 1;                 // table levels
    localparam int LW  = $clog2(LV + 1);
    localparam int TD  = LV * MAX_ELEMS;
    localparam int TAW = $clog2(TD);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_BLD0, S_BLDA, S_BLDB, S_BLDK, S_BLDW,
        S_QLOG, S_QA, S_QB, S_QKA, S_QKB, S_QOUT
    } state_t;

    state_t           state_reg;
    logic             sel_max_reg, built_max_reg, ready_tab_reg;
    logic [CW-1:0]    count_reg;
    logic             last_reg;
    logic [VALUE_WIDTH-1:0] key_in_reg;
    logic [LW-1:0]    lvl_reg;
    logic [CW-1:0]    pos_reg;      // 1-based
    logic [10:0]      left_reg, dist_reg;
    logic [CW-1:0]    cand_a_reg, cand_b_reg;
    logic [VALUE_WIDTH-1:0] key_a_reg;
    logic             out_valid_reg;
    stm_out_t         out_reg;

    logic [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMS];
    logic [CW-1:0]          tab_mem  [TD];
    logic [VALUE_WIDTH-1:0] elem_rd;
    logic [CW-1:0]          tab_rd;

    logic             elem_we, tab_we;
    logic [AW-1:0]    elem_addr;
    logic [TAW-1:0]   tab_addr;
    logic [CW-1:0]    tab_wd;
    logic             take_a;

    function automatic logic [TAW-1:0] slot(input logic [LW-1:0] l,
                                             input logic [CW-1:0] p);
        logic [TAW+CW-1:0] s;
        s = TAW'(l) * TAW'(MAX_ELEMS) + TAW'(p - CW'(1));
        return s[TAW-1:0];
    endfunction

    stm_cmp #(.KW(VALUE_WIDTH)) u_cmp (
        .key_a(key_a_reg), .key_b(elem_rd), .use_max(built_max_reg), .take_a(take_a)
    );

    always_ff @(posedge clk)
    begin
        if (elem_we)
            elem_mem[elem_addr] <= key_in_reg;
        elem_rd <= elem_mem[elem_addr];
        if (tab_we)
            tab_mem[tab_addr] <= tab_wd;
        tab_rd <= tab_mem[tab_addr];
    end

    logic [CW-1:0] half;
    assign half = CW'(1) << (lvl_reg - LW'(1));

    always_comb
    begin
        elem_we   = 1'b0;
        tab_we    = 1'b0;
        elem_addr = '0;
        tab_addr  = '0;
        tab_wd    = pos_reg;
        case (state_reg)
            S_LOAD:
            begin
                elem_we   = (count_reg < CW'(MAX_ELEMS));
                elem_addr = count_reg[AW-1:0];
                tab_we    = elem_we;
                tab_addr  = slot('0, count_reg + CW'(1));
                tab_wd    = count_reg + CW'(1);
            end
            S_BLDA: tab_addr = slot(lvl_reg - LW'(1), pos_reg);
            S_BLDB:
            begin
                tab_addr  = slot(lvl_reg - LW'(1), pos_reg + half);
                elem_addr = AW'(tab_rd - CW'(1));
            end
            S_BLDK: elem_addr = AW'(tab_rd - CW'(1));
            S_BLDW:
            begin
                elem_addr = AW'(tab_rd - CW'(1));
                tab_we    = 1'b1;
                tab_addr  = slot(lvl_reg, pos_reg);
                tab_wd    = take_a ? cand_a_reg : cand_b_reg;
            end
            S_QA: tab_addr = slot(lvl_reg, CW'(left_reg));
            S_QB: tab_addr = slot(lvl_reg, CW'(left_reg + dist_reg - (11'd1 << lvl_reg)));
            S_QKA: elem_addr = AW'(cand_a_reg - CW'(1));
            S_QKB: elem_addr = AW'(cand_b_reg - CW'(1));
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = {31'd0, sel_max_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_max_reg   <= 1'b0;
            built_max_reg <= 1'b0;
            ready_tab_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == 1'b0)
                sel_max_reg <= pwdata[0];
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                if (in_valid && in_ready)
                begin
                    left_reg   <= in_data.left;
                    dist_reg   <= in_data.right - in_data.left + 11'd1;
                    key_in_reg <= in_data.value[VALUE_WIDTH-1:0]
                                  ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH - 1));
                    last_reg   <= in_data.last;
                    lvl_reg    <= '0;
                    if (in_data.operation == OP_LOAD)
                    begin
                        if (ready_tab_reg)
                        begin
                            ready_tab_reg <= 1'b0;
                            count_reg     <= '0;
                        end
                        state_reg <= S_LOAD;
                    end
                    else if (!ready_tab_reg || in_data.left == 11'd0
                             || in_data.left > in_data.right
                             || CW'(in_data.right) > count_reg
                             || in_data.right > 11'(MAX_ELEMS))
                    begin
                        out_reg.best_index <= '0;
                        out_reg.error      <= 1'b1;
                        out_valid_reg      <= 1'b1;
                    end
                    else
                        state_reg <= S_QLOG;
                end
                S_LOAD:
                begin
                    if (count_reg < CW'(MAX_ELEMS))
                        count_reg <= count_reg + CW'(1);
                    if (last_reg)
                    begin
                        built_max_reg <= sel_max_reg;
                        lvl_reg       <= LW'(1);
                        pos_reg       <= CW'(1);
                        state_reg     <= S_BLD0;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_BLD0:
                begin
                    if (lvl_reg >= LW'(LV) || (CW'(1) << lvl_reg) > count_reg)
                    begin
                        ready_tab_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (pos_reg + (CW'(1) << lvl_reg) - CW'(1) > count_reg)
                    begin
                        lvl_reg <= lvl_reg + LW'(1);
                        pos_reg <= CW'(1);
                    end
                    else
                        state_reg <= S_BLDA;
                end
                S_BLDA: state_reg <= S_BLDB;
                S_BLDB:
                begin
                    cand_a_reg <= tab_rd;
                    state_reg  <= S_BLDK;
                end
                S_BLDK:
                begin
                    cand_b_reg <= tab_rd;
                    // swap: key of a must be loaded first; reuse elem read path
                    state_reg  <= S_BLDW;
                end
                S_BLDW:
                begin
                    pos_reg   <= pos_reg + CW'(1);
                    state_reg <= S_BLD0;
                end
                S_QLOG:
                begin
                    if (lvl_reg + LW'(1) < LW'(LV)
                        && (11'd1 << (lvl_reg + LW'(1))) <= dist_reg)
                        lvl_reg <= lvl_reg + LW'(1);
                    else
                        state_reg <= S_QA;
                end
                S_QA: state_reg <= S_QB;
                S_QB:
                begin
                    cand_a_reg <= tab_rd;
                    state_reg  <= S_QKA;
                end
                S_QKA:
                begin
                    cand_b_reg <= tab_rd;
                    state_reg  <= S_QKB;
                end
                S_QKB: state_reg <= S_QOUT;
                S_QOUT:
                begin
                    out_reg.best_index <= 11'(take_a ? cand_a_reg : cand_b_reg);
                    out_reg.error      <= 1'b0;
                    out_valid_reg      <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // key of candidate a is captured from the registered element read in S_BLDK or S_QKB
    always_ff @(posedge clk)
    begin
        if (state_reg == S_BLDK || state_reg == S_QKB)
            key_a_reg <= elem_rd;
    end
endmodule

// File: hw/rtl/stm_checker.sv
// Port-level checker for the sparse table block, bound to the top level.
// Depends on the defines header.
`timescale 1ns / 1ps
`include "sparse_table_range_min_index_defines.svh"
module stm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [10:0] best_index,
    input logic error
);
    `ST_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && error, best_index == 11'd0)
    `ST_ASSERT_IMP(a_no_acc_wait, clk, rst_n, out_valid, !in_ready)
    `ST_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ST_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind sparse_table_range_min_index stm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_index(out_data.best_index), .error(out_data.error)
);
